/* src/bca_pkg.sv */
// Shared constants for the block chain allocator: table marks, mode codes,
// status codes. No dependencies.
package bca_pkg;

  localparam logic [15:0] MARK_END  = 16'hFFFF;
  localparam logic [15:0] MARK_FREE = 16'hFFFE;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

endpackage

/* src/bca_table.sv */
// Next-block table storage: one write port, one read port with registered data.
// No package dependencies.
module bca_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/block_chain_allocator_unit.sv */
// Block chain allocator top level: request sequencer around the next-block table.
// Depends on bca_pkg and bca_table.
//
// After reset the block runs a clearing pass over every table entry and
// holds busy high meanwhile. A request is taken when start is high and busy
// is low; busy then stays high until the result has been shown. The result
// appears on status, block_out and block_total for exactly one cycle with
// done high, and must be captured in that cycle. Request handling is paced by
// the single table read port with its registered read: a lookup reads one
// entry and returns it (an out-of-range lookup skips the read), a free reads
// and rewrites each chain block in turn, and an allocate first frees the old
// chain the same way, then checks the free capacity and, when blocks are
// taken, scans the table up to the highest block taken and marks the chain
// end.
module block_chain_allocator_unit #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  mode,
  input  logic [15:0] target_block,
  input  logic [19:0] byte_count,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] block_out,
  output logic [10:0] block_total
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int PW = CW + 17;
  localparam logic [16:0] NB17    = 17'(NUM_BLOCKS);
  localparam logic [CW-1:0] NBC   = CW'(NUM_BLOCKS);
  localparam logic [CW-1:0] NBC_M = CW'(NUM_BLOCKS - 1);
  localparam logic [20:0] BB      = 21'(BLOCK_BYTES);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_WRD   = 11'b000_0000_0100,
    ST_WWR   = 11'b000_0000_1000,
    ST_MUL   = 11'b000_0001_0000,
    ST_CMP   = 11'b000_0010_0000,
    ST_SCAN  = 11'b000_0100_0000,
    ST_FIN   = 11'b000_1000_0000,
    ST_LRD   = 11'b001_0000_0000,
    ST_LWT   = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  logic [1:0]    op_mode, op_mode_next;
  logic [19:0]   op_bytes, op_bytes_next;
  logic [15:0]   cur, cur_next;
  logic [CW-1:0] steps, steps_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  logic [AW-1:0] pidx, pidx_next;
  logic          pvalid, pvalid_next;
  logic [AW-1:0] prev_blk, prev_blk_next;
  logic          have_prev, have_prev_next;
  logic [19:0]   rem, rem_next;
  logic [CW-1:0] free_count, free_count_next;
  logic [PW-1:0] prod, prod_next;
  logic [10:0]   total, total_next;
  logic [1:0]    res_status, res_status_next;
  logic [15:0]   res_block, res_block_next;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [CW-1:0] steps_inc;

  bca_table #(
    .DEPTH (NUM_BLOCKS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign steps_inc = steps + CW'(1);

  always_comb begin
    state_next      = state;
    op_mode_next    = op_mode;
    op_bytes_next   = op_bytes;
    cur_next        = cur;
    steps_next      = steps;
    scan_idx_next   = scan_idx;
    pidx_next       = pidx;
    pvalid_next     = pvalid;
    prev_blk_next   = prev_blk;
    have_prev_next  = have_prev;
    rem_next        = rem;
    free_count_next = free_count;
    prod_next       = prod;
    total_next      = total;
    res_status_next = res_status;
    res_block_next  = res_block;
    we    = 1'b0;
    waddr = '0;
    wdata = bca_pkg::MARK_FREE;
    re    = 1'b0;
    raddr = '0;

    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = scan_idx[AW-1:0];
        wdata = bca_pkg::MARK_FREE;
        scan_idx_next = scan_idx + CW'(1);
        if (scan_idx == NBC_M) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_mode_next    = mode;
          op_bytes_next   = byte_count;
          cur_next        = target_block;
          steps_next      = '0;
          total_next      = '0;
          res_status_next = bca_pkg::STAT_OK;
          res_block_next  = bca_pkg::MARK_END;
          unique case (mode)
            bca_pkg::MODE_ALLOC: begin
              state_next = ({1'b0, target_block} < NB17) ? ST_WRD : ST_MUL;
            end
            bca_pkg::MODE_FREE: begin
              if ({1'b0, target_block} < NB17) begin
                state_next = ST_WRD;
              end else begin
                if (target_block != bca_pkg::MARK_END) begin
                  res_status_next = bca_pkg::STAT_RANGE;
                end
                state_next = ST_DONE;
              end
            end
            bca_pkg::MODE_LOOKUP: begin
              if ({1'b0, target_block} < NB17) begin
                state_next = ST_LRD;
              end else begin
                res_status_next = bca_pkg::STAT_RANGE;
                state_next      = ST_DONE;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_WRD: begin
        re         = 1'b1;
        raddr      = cur[AW-1:0];
        state_next = ST_WWR;
      end
      ST_WWR: begin
        we         = 1'b1;
        waddr      = cur[AW-1:0];
        wdata      = bca_pkg::MARK_FREE;
        total_next = total + 11'd1;
        if (rdata != bca_pkg::MARK_FREE) begin
          free_count_next = free_count + CW'(1);
        end
        steps_next = steps_inc;
        cur_next   = rdata;
        if (({1'b0, rdata} < NB17) && (steps_inc < NBC)) begin
          state_next = ST_WRD;
        end else if (op_mode == bca_pkg::MODE_ALLOC) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL: begin
        prod_next  = PW'(free_count) * PW'(BLOCK_BYTES);
        state_next = ST_CMP;
      end
      ST_CMP: begin
        total_next     = '0;
        scan_idx_next  = '0;
        pvalid_next    = 1'b0;
        have_prev_next = 1'b0;
        rem_next       = op_bytes;
        if (PW'(op_bytes) > prod) begin
          res_status_next = bca_pkg::STAT_FULL;
          state_next      = ST_DONE;
        end else if (op_bytes == 20'd0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx < NBC) begin
          re = 1'b1;
        end
        raddr         = scan_idx[AW-1:0];
        scan_idx_next = scan_idx + CW'(1);
        pvalid_next   = 1'b1;
        pidx_next     = scan_idx[AW-1:0];
        if (pvalid && (rdata == bca_pkg::MARK_FREE)) begin
          if (have_prev) begin
            we    = 1'b1;
            waddr = prev_blk;
            wdata = 16'(pidx);
          end else begin
            res_block_next = 16'(pidx);
          end
          have_prev_next  = 1'b1;
          prev_blk_next   = pidx;
          total_next      = total + 11'd1;
          free_count_next = free_count - CW'(1);
          if ({1'b0, rem} <= BB) begin
            state_next = ST_FIN;
          end else begin
            rem_next = 20'({1'b0, rem} - BB);
          end
        end
      end
      ST_FIN: begin
        we         = 1'b1;
        waddr      = prev_blk;
        wdata      = bca_pkg::MARK_END;
        state_next = ST_DONE;
      end
      ST_LRD: begin
        re         = 1'b1;
        raddr      = cur[AW-1:0];
        state_next = ST_LWT;
      end
      ST_LWT: begin
        res_block_next = rdata;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      scan_idx   <= '0;
      free_count <= NBC;
      pvalid     <= 1'b0;
      have_prev  <= 1'b0;
    end else begin
      state      <= state_next;
      scan_idx   <= scan_idx_next;
      free_count <= free_count_next;
      pvalid     <= pvalid_next;
      have_prev  <= have_prev_next;
    end
    op_mode    <= op_mode_next;
    op_bytes   <= op_bytes_next;
    cur        <= cur_next;
    steps      <= steps_next;
    pidx       <= pidx_next;
    prev_blk   <= prev_blk_next;
    rem        <= rem_next;
    prod       <= prod_next;
    total      <= total_next;
    res_status <= res_status_next;
    res_block  <= res_block_next;
  end

  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_DONE);
  assign status      = res_status;
  assign block_out   = res_block;
  assign block_total = total;

endmodule

/* tb/tb_block_chain_allocator_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for block_chain_allocator_unit: directed and random
// allocate/free/lookup and unused-mode requests against an in-bench model of
// the next-block table. Depends on bca_pkg and the block_chain_allocator_unit RTL.
module tb_block_chain_allocator_unit;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 512;
  localparam int DRAIN_CYCLES = 4 * NUM_BLOCKS + 300;
  localparam int RANDOM_REQUESTS = 265;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block;
    logic [10:0] total;
  } chain_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  mode = bca_pkg::MODE_ALLOC;
  logic [15:0] target_block = '0;
  logic [19:0] byte_count = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [15:0] block_out;
  logic [10:0] block_total;

  logic [15:0]   next_blk [NUM_BLOCKS];
  chain_result_t pending_results [$];
  chain_result_t want;
  int unsigned   live_heads [$];
  int            err_count = 0;
  bit            quiet_stretch = 1'b0;

  block_chain_allocator_unit #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .target_block(target_block),
    .byte_count  (byte_count),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .block_out   (block_out),
    .block_total (block_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------- table model ----------------
  function automatic int unsigned release_chain(int unsigned head);
    int unsigned cur;
    int unsigned nxt;
    int unsigned cnt;
    cur = head;
    cnt = 0;
    while (cur < NUM_BLOCKS && cnt < NUM_BLOCKS) begin
      nxt = next_blk[cur];
      next_blk[cur] = bca_pkg::MARK_FREE;
      cnt++;
      cur = nxt;
    end
    return cnt;
  endfunction

  function automatic int unsigned free_block_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < NUM_BLOCKS; i++)
      if (next_blk[i] == bca_pkg::MARK_FREE) n++;
    return n;
  endfunction

  function automatic chain_result_t predict_request(logic [1:0] op, logic [15:0] blk,
                                                    logic [19:0] nbytes);
    chain_result_t r;
    int unsigned   needed;
    int unsigned   taken;
    int unsigned   prev;
    r.status = bca_pkg::STAT_OK;
    r.block  = bca_pkg::MARK_END;
    r.total  = '0;
    case (op)
      bca_pkg::MODE_ALLOC: begin
        if (blk < NUM_BLOCKS) void'(release_chain(blk));
        needed = (int'(nbytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (needed > free_block_count()) begin
          r.status = bca_pkg::STAT_FULL;
        end else begin
          taken = 0;
          prev = bca_pkg::MARK_END;
          for (int i = 0; i < NUM_BLOCKS && taken < needed; i++) begin
            if (next_blk[i] == bca_pkg::MARK_FREE) begin
              next_blk[i] = bca_pkg::MARK_END;
              if (prev == bca_pkg::MARK_END) r.block = 16'(i);
              else next_blk[prev] = 16'(i);
              prev = i;
              taken++;
            end
          end
          r.total = 11'(taken);
        end
      end
      bca_pkg::MODE_FREE: begin
        if (blk < NUM_BLOCKS) r.total = 11'(release_chain(blk));
        else if (blk != bca_pkg::MARK_END) r.status = bca_pkg::STAT_RANGE;
      end
      bca_pkg::MODE_LOOKUP: begin
        if (blk < NUM_BLOCKS) r.block = next_blk[blk];
        else r.status = bca_pkg::STAT_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- result checking ----------------
  function automatic void note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("[%0t] result with no request outstanding: status %0d block %0h total %0d",
                   $realtime, status, block_out, block_total);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) note_mismatch("status", want.status, status);
        if (block_out !== want.block) note_mismatch("block_out", want.block, block_out);
        if (block_total !== want.total) note_mismatch("block_total", want.total, block_total);
      end
    end
  end

  // ---------------- request driving ----------------
  task automatic issue_request(input logic [1:0] op, input logic [15:0] blk,
                               input logic [19:0] nbytes, output chain_result_t r);
    @(negedge clk);
    start        <= 1'b1;
    mode         <= op;
    target_block <= blk;
    byte_count   <= nbytes;
    do @(posedge clk); while (busy);
    r = predict_request(op, blk, nbytes);
    pending_results.push_back(r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet_stretch || pick < 70) return;
    if (pick < 95) repeat ($urandom_range(1, 4)) @(negedge clk);
    else repeat ($urandom_range(20, 80)) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void forget_head(int unsigned head);
    foreach (live_heads[i])
      if (live_heads[i] == head) begin
        live_heads.delete(i);
        return;
      end
  endfunction

  // allocate, keeping the head list in step with the model
  task automatic alloc_chain(input logic [15:0] old_head, input logic [19:0] nbytes);
    chain_result_t r;
    forget_head(old_head);
    issue_request(bca_pkg::MODE_ALLOC, old_head, nbytes, r);
    if (r.status == bca_pkg::STAT_OK && r.block != bca_pkg::MARK_END)
      live_heads.push_back(r.block);
  endtask

  task automatic free_chain(input logic [15:0] head);
    chain_result_t r;
    forget_head(head);
    issue_request(bca_pkg::MODE_FREE, head, '0, r);
  endtask

  // ---------------- tests ----------------
  task automatic test_lookup_edges();
    chain_result_t r;
    issue_request(bca_pkg::MODE_LOOKUP, 16'd0, 20'd0, r);
    issue_request(bca_pkg::MODE_LOOKUP, 16'(NUM_BLOCKS - 1), 20'hFFFFF, r);
    issue_request(bca_pkg::MODE_LOOKUP, 16'(NUM_BLOCKS), 20'd0, r);
    issue_request(bca_pkg::MODE_LOOKUP, bca_pkg::MARK_FREE, 20'd0, r);
    issue_request(bca_pkg::MODE_LOOKUP, bca_pkg::MARK_END, 20'd0, r);
  endtask

  task automatic test_free_edges();
    free_chain(bca_pkg::MARK_END);
    free_chain(bca_pkg::MARK_FREE);
    free_chain(16'h8000);
    free_chain(16'(NUM_BLOCKS));
    free_chain(16'd7);
  endtask

  task automatic test_alloc_basic();
    chain_result_t r;
    alloc_chain(bca_pkg::MARK_END, 20'd0);
    alloc_chain(bca_pkg::MARK_END, 20'd1);
    alloc_chain(bca_pkg::MARK_END, 20'(BLOCK_BYTES + 1));
    alloc_chain(16'd0, 20'(BLOCK_BYTES));
    alloc_chain(16'h4321, 20'd1000);
    issue_request(bca_pkg::MODE_LOOKUP, 16'd1, 20'd0, r);
    issue_request(bca_pkg::MODE_LOOKUP, 16'd2, 20'd0, r);
    free_chain(16'd1);
  endtask

  task automatic test_table_limits();
    chain_result_t r;
    wait_idle();
    // old chain is released even though the table cannot hold the request
    alloc_chain(live_heads.size() != 0 ? 16'(live_heads[0]) : bca_pkg::MARK_END,
                20'(524288));
    while (live_heads.size() != 0) free_chain(16'(live_heads[0]));
    alloc_chain(bca_pkg::MARK_END, 20'(524288));
    issue_request(bca_pkg::MODE_LOOKUP, 16'(NUM_BLOCKS - 1), 20'd0, r);
    alloc_chain(bca_pkg::MARK_END, 20'd1);
    free_chain(16'd0);
  endtask

  task automatic test_mode_three();
    chain_result_t r;
    issue_request(MODE_NONE, 16'($urandom_range(0, 65535)), 20'($urandom_range(0, 524288)), r);
  endtask

  function automatic logic [19:0] pick_bytes();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return 20'($urandom_range(0, 4 * BLOCK_BYTES));
    if (pick < 95) return 20'($urandom_range(4 * BLOCK_BYTES + 1, 65536));
    return 20'($urandom_range(65537, 524288));
  endfunction

  task automatic test_random_traffic();
    chain_result_t r;
    int unsigned   pick;
    logic [15:0]   head;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
      if (n % 70 == 69) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 45 && free_block_count() < 300 && live_heads.size() != 0) pick = 50;
      if (pick < 45) begin
        if (pick < 3) head = 16'($urandom_range(0, 65535));
        else if (live_heads.size() != 0 && $urandom_range(0, 1))
          head = 16'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
        else head = bca_pkg::MARK_END;
        alloc_chain(head, pick_bytes());
      end else if (pick < 75) begin
        if (live_heads.size() != 0)
          free_chain(16'(live_heads[$urandom_range(0, live_heads.size() - 1)]));
        else free_chain(16'($urandom_range(0, NUM_BLOCKS - 1)));
      end else if (pick < 88) begin
        if (live_heads.size() != 0 && $urandom_range(0, 1))
          head = 16'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
        else head = 16'($urandom_range(0, NUM_BLOCKS - 1));
        issue_request(bca_pkg::MODE_LOOKUP, head, 20'($urandom_range(0, 1048575)), r);
      end else if (pick < 95) begin
        issue_request(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                      20'($urandom_range(0, 524288)), r);
        if (r.status == bca_pkg::STAT_OK && r.block != bca_pkg::MARK_END && r.total != 0)
          live_heads.push_back(r.block);
      end else begin
        // release from a random block, which may lie inside a chain and leave its head dangling
        issue_request(bca_pkg::MODE_FREE, 16'($urandom_range(0, NUM_BLOCKS - 1)), '0, r);
      end
      idle_gap();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) next_blk[i] = bca_pkg::MARK_FREE;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_lookup_edges();
    test_free_edges();
    test_alloc_basic();
    test_table_limits();
    test_mode_three();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/bca_pkg.sv
src/bca_table.sv
src/block_chain_allocator_unit.sv
tb/tb_block_chain_allocator_unit.sv
